FILE: hdl/nta_pkg.sv
// Package for the number to ASCII line converter: constants, microcode and helpers.
package nta_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = VALUE_BITS;
	localparam int CNT_W      = $clog2(VALUE_BITS);
	localparam int ND_W       = $clog2(MAX_DIGITS + 1);
	localparam int STK_W      = $clog2(MAX_DIGITS);
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;
	localparam int PC_W       = 3;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [CHAR_W-1:0]  CHAR_T      = 8'h54;
	localparam logic [CHAR_W-1:0]  CHAR_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A      = 8'h41;
	localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

	typedef logic [PC_W-1:0] step_t;

	// Program addresses.
	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_DIV_INIT = 3'd1;
	localparam step_t STEP_DIV_STEP = 3'd2;
	localparam step_t STEP_PUSH     = 3'd3;
	localparam step_t STEP_T0       = 3'd4;
	localparam step_t STEP_T1       = 3'd5;
	localparam step_t STEP_DIGIT    = 3'd6;
	localparam step_t STEP_NL       = 3'd7;

	typedef enum logic [2:0] {
		OP_WAIT_IN,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PUSH,
		OP_EMIT_T,
		OP_EMIT_DIGIT,
		OP_EMIT_NL
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_CNT_NZ,
		COND_MORE_DIGITS,
		COND_ND_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// The program: one control word per step. When a step completes, the
	// sequencer jumps to target if the condition holds, else falls through.
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		unique case (pc)
			STEP_IDLE:     w = '{OP_WAIT_IN,    COND_NEVER,       STEP_IDLE};
			STEP_DIV_INIT: w = '{OP_DIV_INIT,   COND_NEVER,       STEP_IDLE};
			STEP_DIV_STEP: w = '{OP_DIV_STEP,   COND_CNT_NZ,      STEP_DIV_STEP};
			STEP_PUSH:     w = '{OP_PUSH,       COND_MORE_DIGITS, STEP_DIV_INIT};
			STEP_T0:       w = '{OP_EMIT_T,     COND_NEVER,       STEP_IDLE};
			STEP_T1:       w = '{OP_EMIT_T,     COND_NEVER,       STEP_IDLE};
			STEP_DIGIT:    w = '{OP_EMIT_DIGIT, COND_ND_MORE,     STEP_DIGIT};
			STEP_NL:       w = '{OP_EMIT_NL,    COND_ALWAYS,      STEP_IDLE};
			default:       w = '{OP_WAIT_IN,    COND_NEVER,       STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [RADIX_W-1:0] effective_base(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		if (r < RADIX_MIN) begin
			b = DEC_DIGITS;
		end else if (r > RADIX_MAX) begin
			b = RADIX_MAX;
		end else begin
			b = r;
		end
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage

FILE: hdl/number_to_ascii_line.sv
// Top level of the number to ASCII line converter with its microcoded sequencer.
//
//  Channel   Signals                              Contents
//  --------  -----------------------------------  ----------------------------------
//  in        in_tvalid, in_tready, in_tdata[31:0]  value to convert
//  out       out_tvalid, out_tready,               one text byte per request;
//            out_tdata[7:0], out_tlast             tlast on the closing newline
//  config    cfg_we, cfg_wdata[5:0]                radix, written at once
//
// Each digit is found by clearing the remainder, running 32 restoring
// division steps (one quotient bit each, through a single 7-bit subtractor),
// and pushing the digit. A line of n digits is then sent as two T bytes,
// the n digits and a newline.
// Reset sets the radix to ten and puts the sequencer at its wait step.
// A stalled sink holds the sequencer in its current emit step; a new value is
// taken as soon as the sequencer is back at the wait step, even while the
// newline still waits in the output register.
module number_to_ascii_line (
	input  logic                         clk,
	input  logic                         arst_n,
	// value
	input  logic [nta_pkg::VALUE_BITS-1:0] in_tdata,
	input  logic                         in_tvalid,
	output logic                         in_tready,
	// char_out
	output logic [nta_pkg::CHAR_W-1:0]   out_tdata,
	output logic                         out_tlast,
	output logic                         out_tvalid,
	input  logic                         out_tready,
	input  logic                         cfg_we,
	input  logic [nta_pkg::RADIX_W-1:0]  cfg_wdata
);
	import nta_pkg::*;

	// Sequencer.
	step_t                   pc_q;
	step_t                   pc_next;
	ucode_t                  uw;
	logic                    step_done;
	logic                    cond_true;

	// Datapath registers.
	logic [RADIX_W-1:0]      radix_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [RADIX_W-1:0]      rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [ND_W-1:0]         nd_q;
	logic [RADIX_W-1:0]      stack_q [MAX_DIGITS];

	logic [CHAR_W-1:0]       out_data_q;
	logic                    out_last_q;
	logic                    out_valid_q;

	// Combinational datapath.
	logic [RADIX_W-1:0]      base;
	logic [RADIX_W:0]        trial;
	logic                    q_bit;
	logic [RADIX_W-1:0]      rem_next;
	logic [ND_W-1:0]         nd_m1;
	logic                    slot_free;
	logic                    emit;
	logic [CHAR_W-1:0]       emit_char;

	assign base      = effective_base(radix_q);
	assign uw        = ucode_rom(pc_q);
	assign slot_free = !out_valid_q || out_tready;
	assign nd_m1     = nd_q - 1'b1;

	// One restoring division step: shift in the next dividend bit and
	// subtract the base when it fits.
	assign trial    = {rem_q, val_q[VALUE_BITS-1]};
	assign q_bit    = (trial >= {1'b0, base});
	assign rem_next = q_bit ? RADIX_W'(trial - {1'b0, base}) : RADIX_W'(trial);

	always_comb begin
		step_done = 1'b1;
		emit      = 1'b0;
		emit_char = CHAR_T;
		unique case (uw.op)
			OP_WAIT_IN: begin
				step_done = in_tvalid;
			end
			OP_EMIT_T: begin
				step_done = slot_free;
				emit      = slot_free;
				emit_char = CHAR_T;
			end
			OP_EMIT_DIGIT: begin
				step_done = slot_free;
				emit      = slot_free;
				emit_char = digit_char(stack_q[nd_m1[STK_W-1:0]]);
			end
			OP_EMIT_NL: begin
				step_done = slot_free;
				emit      = slot_free;
				emit_char = CHAR_NL;
			end
			default: begin
				step_done = 1'b1;
			end
		endcase

		// Conditions are evaluated on the register values of this step.
		unique case (uw.cond)
			COND_ALWAYS:      cond_true = 1'b1;
			COND_CNT_NZ:      cond_true = (cnt_q != '0);
			COND_MORE_DIGITS: cond_true = (val_q != '0) &&
				(nd_q != ND_W'(MAX_DIGITS - 1));
			COND_ND_MORE:     cond_true = (nd_q != ND_W'(1));
			default:          cond_true = 1'b0;
		endcase

		if (!step_done) begin
			pc_next = pc_q;
		end else if (cond_true) begin
			pc_next = uw.target;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers follow the control word of the current step.
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_WAIT_IN: begin
				if (in_tvalid) begin
					val_q <= in_tdata;
					nd_q  <= '0;
				end
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				cnt_q <= CNT_W'(VALUE_BITS - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= rem_next;
				val_q <= {val_q[VALUE_BITS-2:0], q_bit};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_PUSH: begin
				stack_q[nd_q[STK_W-1:0]] <= rem_q;
				nd_q <= nd_q + 1'b1;
			end
			OP_EMIT_DIGIT: begin
				if (slot_free) begin
					nd_q <= nd_m1;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			out_data_q <= emit_char;
			out_last_q <= (uw.op == OP_EMIT_NL);
		end
	end

	assign in_tready  = (uw.op == OP_WAIT_IN);
	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;
	assign out_tlast  = out_last_q;

endmodule

FILE: hdl/nta_checker.sv
// Port-level checker for the number to ASCII line converter, bound to the top level.
module nta_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_tvalid,
	input logic                           in_tready,
	input logic [nta_pkg::CHAR_W-1:0]     out_tdata,
	input logic                           out_tlast,
	input logic                           out_tvalid,
	input logic                           out_tready
);
	import nta_pkg::*;

	// A waiting byte stays put until the sink takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
		else $error("output byte changed while stalled");

	// Once a value is taken, conversion runs before another can enter.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_tvalid && in_tready |=> !in_tready)
		else $error("second request accepted during conversion");

	// The marked byte is always the newline.
	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && out_tlast |-> out_tdata == CHAR_NL)
		else $error("last byte is not a newline");

	// No newline appears inside a line.
	a_no_inner_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tlast |-> out_tdata != CHAR_NL)
		else $error("unmarked newline byte");

endmodule

bind number_to_ascii_line nta_checker u_nta_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_tvalid  (in_tvalid),
	.in_tready  (in_tready),
	.out_tdata  (out_tdata),
	.out_tlast  (out_tlast),
	.out_tvalid (out_tvalid),
	.out_tready (out_tready)
);
